[design/bpm_pkg.sv]
`default_nettype none

package bpm_pkg;

  localparam int MAX_NEEDLE_DEF    = 16;
  localparam int POSITION_BITS_DEF = 32;

  localparam int DATA_W   = 8;
  localparam int POS_W    = 32;
  localparam int CFG_W    = 64;
  localparam int NEEDLE_W = 2 * CFG_W;
  localparam int LEN_W    = 5;
  localparam int IDX_W    = 8;

  localparam logic [IDX_W-1:0] REG_NEEDLE_LOW  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_NEEDLE_HIGH = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_NEEDLE_LEN  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_FIND_ALL    = IDX_W'(3);

  typedef struct packed {
    logic [NEEDLE_W-1:0] needle;
    logic [LEN_W-1:0]    needle_length;
    logic                find_all;
  } cfg_t;

  typedef struct packed {
    logic             match_found;
    logic [POS_W-1:0] match_position;
    logic             last_result;
  } res_t;

endpackage

`default_nettype wire

[design/bpm_front.sv]
`default_nettype none

module bpm_front
  import bpm_pkg::*;
#(
  parameter int MAX_NEEDLE    = MAX_NEEDLE_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire  cfg_t        cfg,
  input  wire               in_valid,
  input  wire  [DATA_W-1:0] in_byte,
  input  wire               in_last,
  input  wire               q_ready,
  output logic              q_push,
  output res_t              q_item
);

  localparam int CNT_W = (POSITION_BITS < 32) ? POSITION_BITS : 32;
  localparam int WIN_D = (MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1;
  localparam int HIDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

  logic [DATA_W-1:0] window_r   [WIN_D];
  logic [DATA_W-1:0] window_nxt [WIN_D];
  logic [CNT_W-1:0]  seen_r, seen_nxt, seen_inc;
  logic              first_r, first_nxt;

  logic [DATA_W-1:0] hist [MAX_NEEDLE];
  logic [LEN_W-1:0]  len_u;
  logic              all_eq;
  logic              hit;
  logic              accept;
  logic [CNT_W-1:0]  pos;

  assign accept = in_valid & q_ready;

  always_comb begin
    if (cfg.needle_length == '0) begin
      len_u = LEN_W'(1);
    end else if (cfg.needle_length > LEN_W'(MAX_NEEDLE)) begin
      len_u = LEN_W'(MAX_NEEDLE);
    end else begin
      len_u = cfg.needle_length;
    end
  end

  assign seen_inc = (seen_r != '1) ? seen_r + CNT_W'(1) : seen_r;

  // hist[0] is the current byte, hist[i] the byte i beats back
  always_comb begin
    hist[0] = in_byte;
    for (int i = 1; i < MAX_NEEDLE; i++) begin
      hist[i] = window_r[i-1];
    end
  end

  // needle byte j lines up with the byte len-1-j beats back
  always_comb begin
    logic [LEN_W-1:0] sel;
    all_eq = 1'b1;
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      sel = len_u - LEN_W'(1) - LEN_W'(j);
      if (LEN_W'(j) < len_u) begin
        if (hist[sel[HIDX_W-1:0]] != cfg.needle[DATA_W*j +: DATA_W]) begin
          all_eq = 1'b0;
        end
      end
    end
  end

  assign hit = all_eq && !first_r && (seen_inc >= CNT_W'(len_u));
  assign pos = seen_inc - CNT_W'(len_u) + CNT_W'(1);

  assign q_push = accept & (hit | in_last);
  always_comb begin
    q_item.match_found    = hit;
    q_item.match_position = hit ? POS_W'(pos) : '0;
    q_item.last_result    = in_last;
  end

  always_comb begin
    window_nxt = window_r;
    seen_nxt   = seen_r;
    first_nxt  = first_r;
    if (accept) begin
      if (in_last) begin
        for (int k = 0; k < WIN_D; k++) begin
          window_nxt[k] = '0;
        end
        seen_nxt  = '0;
        first_nxt = 1'b0;
      end else begin
        for (int k = WIN_D - 1; k > 0; k--) begin
          window_nxt[k] = window_r[k-1];
        end
        window_nxt[0] = in_byte;
        seen_nxt      = seen_inc;
        if (hit && !cfg.find_all) begin
          first_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WIN_D; k++) begin
        window_r[k] <= '0;
      end
      seen_r  <= '0;
      first_r <= 1'b0;
    end else begin
      window_r <= window_nxt;
      seen_r   <= seen_nxt;
      first_r  <= first_nxt;
    end
  end

endmodule

`default_nettype wire

[design/bpm_queue.sv]
`default_nettype none

module bpm_queue
  import bpm_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   push,
  input  wire res_t push_item,
  output logic  has_space,
  output logic  out_valid,
  input  wire   out_ready,
  output res_t  out_item
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  res_t               mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     count_r, count_nxt;
  logic               pop;

  assign has_space = (count_r != (PTR_W+1)'(DEPTH));
  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign pop       = out_valid & out_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (PTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[design/byte_pattern_match_stream.sv]
// each result is registered in the queue and shows on out_ from there
// one byte per cycle while the queue has space; the window compare is
// done in parallel in the beat's own cycle and results sit in a
// four-entry queue; in_tready drops only while that queue is full
// reset (rst_n low, synchronous) clears window, byte count, first-hit flag
// and the queue; needle is zero, needle_length 1, find_all 1
`default_nettype none

module byte_pattern_match_stream
  import bpm_pkg::*;
#(
  parameter int MAX_NEEDLE    = MAX_NEEDLE_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [IDX_W-1:0]  cfg_index,
  input  wire  [CFG_W-1:0]  cfg_data,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire  [DATA_W-1:0] in_tdata,   // [7:0] data_byte
  input  wire               in_tlast,   // end_of_haystack
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [POS_W-1:0]  out_tdata,  // [31:0] match_position
  output logic              out_tuser,  // [0] match_found
  output logic              out_tlast   // last_result
);

  cfg_t cfg_r, cfg_nxt;
  logic q_push;
  logic q_space;
  res_t q_item;
  res_t out_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_NEEDLE_LOW:  cfg_nxt.needle[CFG_W-1:0]        = cfg_data;
        REG_NEEDLE_HIGH: cfg_nxt.needle[NEEDLE_W-1:CFG_W] = cfg_data;
        REG_NEEDLE_LEN:  cfg_nxt.needle_length            = cfg_data[LEN_W-1:0];
        REG_FIND_ALL:    cfg_nxt.find_all                 = cfg_data[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.needle        <= '0;
      cfg_r.needle_length <= LEN_W'(1);
      cfg_r.find_all      <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = q_space;

  bpm_front #(
    .MAX_NEEDLE    (MAX_NEEDLE),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .q_ready  (q_space),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  bpm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .has_space (q_space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = out_item.match_position;
  assign out_tuser = out_item.match_found;
  assign out_tlast = out_item.last_result;

endmodule

`default_nettype wire
